### design/battery_coulomb_counter_core_defines.svh
// assertion macros for the coulomb counter core
`ifndef BATTERY_COULOMB_COUNTER_CORE_DEFINES_SVH
`define BATTERY_COULOMB_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bcc_pkg.sv
// shared types and constants of the coulomb counter core
package bcc_pkg;

    localparam int RemW      = 41;
    localparam int DivW      = 40;
    localparam int CntW      = 5;
    localparam int CodeSteps = 16;
    localparam int CycSteps  = 32;

    // millivolts per full code span (5 V)
    localparam logic [12:0] MvPerCodeSpan = 13'd5000;

    localparam logic [4:0]  CellCountRst    = 5'd4;
    localparam logic [15:0] FullCellMvRst   = 16'd4200;
    localparam logic [16:0] ChargeDetectRst = 17'd100;
    localparam logic [39:0] CapacityRst     = 40'd10800000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CODE,
        ST_CYC_LOAD,
        ST_CYC,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_CELL_COUNT       = 3'd0,
        REG_FULL_CELL_MV     = 3'd1,
        REG_CHARGE_DETECT_MA = 3'd2,
        REG_CHARGE_CAPACITY  = 3'd3,
        REG_CYCLE_CAPACITY   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [DivW-1:0] divisor;
        logic            bit_in;
    } div_step_in_t;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic            q_bit;
    } div_step_out_t;

endpackage

### design/bcc_div_step.sv
// one restoring division step: shift in a dividend bit, trial subtract
module bcc_div_step import bcc_pkg::*; (
    input  div_step_in_t  step_in,
    output div_step_out_t step_out
);

    logic [RemW-1:0] shifted;
    logic [RemW:0]   trial;

    assign shifted = {step_in.rem[RemW-2:0], step_in.bit_in};
    assign trial   = {1'b0, shifted} - {{(RemW + 1 - DivW){1'b0}}, step_in.divisor};

    always_comb begin
        if (!trial[RemW]) begin
            step_out.rem   = trial[RemW-1:0];
            step_out.q_bit = 1'b1;
        end else begin
            step_out.rem   = shifted;
            step_out.q_bit = 1'b0;
        end
    end

endmodule

### design/battery_coulomb_counter_core.sv
// coulomb counter core: charge since full, equivalent full cycles, per-cell voltage code
// a new item is accepted only in idle, after the previous result has entered the output
// register; most of the work per item is done by the shared one-bit-per-cycle divider (16
// steps for the cell code, 32 for the cycle count, which is skipped when it saturates)
// reset: synchronous active-low aresetn restores register defaults and clears all counters
`include "battery_coulomb_counter_core_defines.svh"

module battery_coulomb_counter_core import bcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // pack_mv[15:0], current_ma[33:16], sample_ms[65:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // charge_from_full[40:0], full_cycles_q16[72:41],
                                    // cell_code[88:73]
    output logic        m_tuser,    // full_reset
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_wdata
);

    // configuration
    logic [4:0]  cell_count_reg;
    logic [15:0] full_cell_mv_reg;
    logic [16:0] charge_detect_reg;
    logic [39:0] charge_cap_reg;
    logic [39:0] cycle_cap_reg;

    // control and state
    state_t            state_reg, state_next;
    logic              started_reg, started_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic signed [40:0] charge_acc_reg, charge_acc_next;
    logic [63:0]       thr_reg, thr_next;
    logic [CntW-1:0]   step_cnt_reg, step_cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // item payload and datapath
    logic [15:0]        pack_reg, pack_next;
    logic signed [17:0] cur_reg, cur_next;
    logic [31:0]        ts_reg, ts_next;
    logic signed [48:0] prod_reg, prod_next;
    logic               full_reg, full_next;
    logic               code_sat_reg, code_sat_next;
    logic [15:0]        code_reg, code_next;
    logic [31:0]        cyc_reg, cyc_next;
    logic [RemW-1:0]    rem_reg, rem_next;
    logic [31:0]        dvd_reg, dvd_next;
    logic [31:0]        quo_reg, quo_next;

    // result register
    logic [40:0] out_charge_reg, out_charge_next;
    logic [31:0] out_cyc_reg, out_cyc_next;
    logic [15:0] out_code_reg, out_code_next;
    logic        out_full_reg, out_full_next;

    // derived values
    logic [4:0]         cells;
    logic [17:0]        cell_div;
    logic [20:0]        full_pack_mv;
    logic [39:0]        ccap;
    logic [31:0]        time_base;
    logic [31:0]        time_diff;
    logic [30:0]        dms;
    logic signed [48:0] mul_res;
    logic signed [49:0] charge_sum;
    logic signed [49:0] neg_cap;
    logic [47:0]        abs_prod;
    logic [64:0]        thr_sum;
    logic               in_accept;

    div_step_in_t  div_in;
    div_step_out_t div_out;

    assign cells        = (cell_count_reg == 5'd0) ? 5'd1 : cell_count_reg;
    assign cell_div     = {5'b0, MvPerCodeSpan} * {13'b0, cells};
    assign full_pack_mv = {5'b0, full_cell_mv_reg} * {16'b0, cells};
    assign ccap         = (cycle_cap_reg == 40'd0) ? 40'd1 : cycle_cap_reg;

    assign time_base = started_reg ? last_time_reg : ts_reg;
    assign time_diff = ts_reg - time_base;
    assign dms       = time_diff[31] ? 31'd0 : time_diff[30:0];
    assign mul_res   = 49'(cur_reg * $signed({1'b0, dms}));

    assign charge_sum = {{9{charge_acc_reg[40]}}, charge_acc_reg} + {prod_reg[48], prod_reg};
    assign neg_cap    = -$signed({10'b0, charge_cap_reg});
    assign abs_prod   = prod_reg[48] ? 48'(-prod_reg) : prod_reg[47:0];
    assign thr_sum    = {1'b0, thr_reg} + {17'b0, abs_prod};

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    assign div_in.rem     = rem_reg;
    assign div_in.divisor = (state_reg == ST_CODE) ? {22'b0, cell_div} : ccap;
    assign div_in.bit_in  = dvd_reg[31];

    bcc_div_step u_div_step (
        .step_in  (div_in),
        .step_out (div_out)
    );

    always_comb begin
        state_next      = state_reg;
        started_next    = started_reg;
        last_time_next  = last_time_reg;
        charge_acc_next = charge_acc_reg;
        thr_next        = thr_reg;
        step_cnt_next   = step_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        pack_next       = pack_reg;
        cur_next        = cur_reg;
        ts_next         = ts_reg;
        prod_next       = prod_reg;
        full_next       = full_reg;
        code_sat_next   = code_sat_reg;
        code_next       = code_reg;
        cyc_next        = cyc_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        out_charge_next = out_charge_reg;
        out_cyc_next    = out_cyc_reg;
        out_code_next   = out_code_reg;
        out_full_next   = out_full_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    pack_next  = s_tdata[15:0];
                    cur_next   = $signed(s_tdata[33:16]);
                    ts_next    = s_tdata[65:34];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next      = mul_res;
                full_next      = ({5'b0, pack_reg} >= full_pack_mv)
                                 && ($signed({cur_reg[17], cur_reg})
                                     > $signed({2'b0, charge_detect_reg}));
                started_next   = 1'b1;
                last_time_next = ts_reg;
                state_next     = ST_ACC;
            end
            ST_ACC: begin
                if (full_reg || charge_sum > 50'sd0) begin
                    charge_acc_next = '0;
                end else if (charge_sum < neg_cap) begin
                    charge_acc_next = neg_cap[40:0];
                end else begin
                    charge_acc_next = charge_sum[40:0];
                end
                thr_next      = thr_sum[64] ? '1 : thr_sum[63:0];
                code_sat_next = ({2'b0, pack_reg} >= cell_div);
                rem_next      = {25'b0, pack_reg};
                dvd_next      = '0;
                step_cnt_next = CntW'(CodeSteps - 1);
                state_next    = ST_CODE;
            end
            ST_CODE: begin
                rem_next = div_out.rem;
                quo_next = {quo_reg[30:0], div_out.q_bit};
                dvd_next = {dvd_reg[30:0], 1'b0};
                if (step_cnt_reg == '0) begin
                    code_next  = code_sat_reg ? 16'hFFFF : {quo_reg[14:0], div_out.q_bit};
                    state_next = ST_CYC_LOAD;
                end else begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            ST_CYC_LOAD: begin
                if (thr_reg[63:16] >= {8'b0, ccap}) begin
                    cyc_next   = '1;
                    state_next = ST_DONE;
                end else begin
                    rem_next      = thr_reg[56:16];
                    dvd_next      = {thr_reg[15:0], 16'b0};
                    step_cnt_next = CntW'(CycSteps - 1);
                    state_next    = ST_CYC;
                end
            end
            ST_CYC: begin
                rem_next = div_out.rem;
                quo_next = {quo_reg[30:0], div_out.q_bit};
                dvd_next = {dvd_reg[30:0], 1'b0};
                if (step_cnt_reg == '0) begin
                    cyc_next   = {quo_reg[30:0], div_out.q_bit};
                    state_next = ST_DONE;
                end else begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_charge_next = charge_acc_reg;
                    out_cyc_next    = cyc_reg;
                    out_code_next   = code_reg;
                    out_full_next   = full_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg    <= CellCountRst;
            full_cell_mv_reg  <= FullCellMvRst;
            charge_detect_reg <= ChargeDetectRst;
            charge_cap_reg    <= CapacityRst;
            cycle_cap_reg     <= CapacityRst;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CELL_COUNT:       cell_count_reg    <= cfg_wdata[4:0];
                REG_FULL_CELL_MV:     full_cell_mv_reg  <= cfg_wdata[15:0];
                REG_CHARGE_DETECT_MA: charge_detect_reg <= cfg_wdata[16:0];
                REG_CHARGE_CAPACITY:  charge_cap_reg    <= cfg_wdata;
                REG_CYCLE_CAPACITY:   cycle_cap_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            last_time_reg  <= '0;
            charge_acc_reg <= '0;
            thr_reg        <= '0;
            step_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            last_time_reg  <= last_time_next;
            charge_acc_reg <= charge_acc_next;
            thr_reg        <= thr_next;
            step_cnt_reg   <= step_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pack_reg       <= pack_next;
        cur_reg        <= cur_next;
        ts_reg         <= ts_next;
        prod_reg       <= prod_next;
        full_reg       <= full_next;
        code_sat_reg   <= code_sat_next;
        code_reg       <= code_next;
        cyc_reg        <= cyc_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        quo_reg        <= quo_next;
        out_charge_reg <= out_charge_next;
        out_cyc_reg    <= out_cyc_next;
        out_code_reg   <= out_code_next;
        out_full_reg   <= out_full_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_code_reg, out_cyc_reg, out_charge_reg};
    assign m_tuser  = out_full_reg;

    `BCC_ASSERT_NEXT(a_accept_starts_mul, s_tvalid && s_tready, state_reg == ST_MUL, "accepted item did not start")
    `BCC_ASSERT_NOW(a_charge_not_positive, 1'b1, charge_acc_reg <= 41'sd0, "charge counter above full")
    `BCC_ASSERT_NOW(a_full_clears_charge, m_tvalid && m_tuser, m_tdata[40:0] == 41'd0, "full item with nonzero charge")
    `BCC_ASSERT_NOW(a_rem_below_divisor, (state_reg == ST_CODE && !code_sat_reg) || state_reg == ST_CYC, rem_reg < {1'b0, div_in.divisor}, "divider remainder out of range")

endmodule
